[rtl/core/rou_pkg.sv]
// ----------------------------------------------------------------------------
// rou_pkg
// shared types and constants of the rectangle operation unit
// ----------------------------------------------------------------------------
`default_nettype none

package rou_pkg;

    // width of every coordinate port
    localparam int FIELD_W = 16;

    // widest coordinate the datapath supports
    localparam int WIDE_W = 32;

    // default internal coordinate width
    localparam int COORD_WIDTH_DEFAULT = 16;

    // subtract cuts at most this many pieces
    localparam int N_PIECES = 4;

    // command codes
    typedef enum logic [2:0] {
        CMD_INTERSECT  = 3'd0,
        CMD_UNION      = 3'd1,
        CMD_BOUND      = 3'd2,
        CMD_SUBTRACT   = 3'd3,
        CMD_COVERED_BY = 3'd4,
        CMD_EQUAL      = 3'd5,
        CMD_IS_EMPTY   = 3'd6,
        CMD_NORMALIZE  = 3'd7
    } cmd_t;

    // status of one result from the alu
    typedef struct packed {
        logic                flag;
        logic                last;
        logic [N_PIECES-1:0] pick;
    } alu_status_t;

endpackage

`default_nettype wire

[rtl/core/rectangle_operation_unit.sv]
// ----------------------------------------------------------------------------
// rectangle_operation_unit
// clip-rectangle alu for two half-open rectangles per item
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries a command and rectangles A and
//   B; output channel (out_valid/out_ready) carries one result rectangle with
//   flag and last. Every command gives one result item except subtract, which
//   gives one to four pieces, the final one marked by last.
//   An accepted item sits in the input register, passes the comparator/mux
//   datapath, and lands in the result register once that register is free.
//   Throughput is one item per cycle for single-result commands while the
//   receiver is ready; a subtract item stays in the input register until its
//   last piece leaves, one piece leaving the datapath per cycle while the
//   receiver is ready.
//   The input register and the result register each hold one item, so a new
//   item is taken while a result waits. When the receiver stalls, the result
//   holds and in_ready drops once the input register is also occupied.
//   Reset clears both valid flags and the piece mask; nothing else is kept.
//   COORD_WIDTH sets the internal coordinate width: the low COORD_WIDTH bits
//   of each field are used, results are sign-extended or truncated back to the port width.
// ----------------------------------------------------------------------------
`default_nettype none

module rectangle_operation_unit #(
    parameter int COORD_WIDTH = rou_pkg::COORD_WIDTH_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [2:0]                        command,
    input  wire logic signed [rou_pkg::FIELD_W-1:0] a_left,
    input  wire logic signed [rou_pkg::FIELD_W-1:0] a_top,
    input  wire logic signed [rou_pkg::FIELD_W-1:0] a_right,
    input  wire logic signed [rou_pkg::FIELD_W-1:0] a_bottom,
    input  wire logic signed [rou_pkg::FIELD_W-1:0] b_left,
    input  wire logic signed [rou_pkg::FIELD_W-1:0] b_top,
    input  wire logic signed [rou_pkg::FIELD_W-1:0] b_right,
    input  wire logic signed [rou_pkg::FIELD_W-1:0] b_bottom,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [rou_pkg::FIELD_W-1:0]     res_left,
    output logic signed [rou_pkg::FIELD_W-1:0]     res_top,
    output logic signed [rou_pkg::FIELD_W-1:0]     res_right,
    output logic signed [rou_pkg::FIELD_W-1:0]     res_bottom,
    output logic                                   flag,
    output logic                                   last
);

    localparam int FW = rou_pkg::FIELD_W;
    localparam int WW = rou_pkg::WIDE_W;
    localparam int NP = rou_pkg::N_PIECES;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    // input register
    logic                 s1_valid_reg;
    rou_pkg::cmd_t        s1_cmd_reg;
    logic [FW-1:0]        s1_field_reg [8];
    logic [NP-1:0]        done_reg;

    // result register
    logic                 out_valid_reg;
    logic signed [FW-1:0] res_l_reg;
    logic signed [FW-1:0] res_t_reg;
    logic signed [FW-1:0] res_r_reg;
    logic signed [FW-1:0] res_b_reg;
    logic                 flag_reg;
    logic                 last_reg;

    coord_t               crd [8];
    coord_t               r_l;
    coord_t               r_t;
    coord_t               r_r;
    coord_t               r_b;
    logic signed [WW-1:0] w_l;
    logic signed [WW-1:0] w_t;
    logic signed [WW-1:0] w_r;
    logic signed [WW-1:0] w_b;
    rou_pkg::alu_status_t st;
    logic                 out_free;
    logic                 s1_fire;
    logic                 in_fire;

    // handshake
    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || (out_free && st.last);
    assign in_fire  = in_valid && in_ready;

    // field to coordinate: low bits, sign taken at the coordinate width
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            crd[k] = coord_t'({{(WW - FW){1'b0}}, s1_field_reg[k]});
        end
    end

    rou_alu #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_alu (
        .cmd    (s1_cmd_reg),
        .a_l    (crd[0]),
        .a_t    (crd[1]),
        .a_r    (crd[2]),
        .a_b    (crd[3]),
        .b_l    (crd[4]),
        .b_t    (crd[5]),
        .b_r    (crd[6]),
        .b_b    (crd[7]),
        .done   (done_reg),
        .r_l    (r_l),
        .r_t    (r_t),
        .r_r    (r_r),
        .r_b    (r_b),
        .status (st)
    );

    // coordinate back to port width
    assign w_l = WW'(r_l);
    assign w_t = WW'(r_t);
    assign w_r = WW'(r_r);
    assign w_b = WW'(r_b);

    // input register control and payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= '0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire && st.last)
                s1_valid_reg <= 1'b0;
            if (s1_fire)
            begin
                if (st.last)
                    done_reg <= '0;
                else
                    done_reg <= done_reg | st.pick;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg      <= rou_pkg::cmd_t'(command);
            s1_field_reg[0] <= a_left;
            s1_field_reg[1] <= a_top;
            s1_field_reg[2] <= a_right;
            s1_field_reg[3] <= a_bottom;
            s1_field_reg[4] <= b_left;
            s1_field_reg[5] <= b_top;
            s1_field_reg[6] <= b_right;
            s1_field_reg[7] <= b_bottom;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            res_l_reg <= w_l[FW-1:0];
            res_t_reg <= w_t[FW-1:0];
            res_r_reg <= w_r[FW-1:0];
            res_b_reg <= w_b[FW-1:0];
            flag_reg  <= st.flag;
            last_reg  <= st.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign res_left   = res_l_reg;
    assign res_top    = res_t_reg;
    assign res_right  = res_r_reg;
    assign res_bottom = res_b_reg;
    assign flag       = flag_reg;
    assign last       = last_reg;

    // checks
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (s1_cmd_reg != rou_pkg::CMD_SUBTRACT) |-> st.last)
        else $error("single-result command without last");

    a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $onehot(st.pick))
        else $error("piece selection not one-hot");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> (done_reg == '0))
        else $error("piece mask set with empty input register");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(done_reg))
        else $error("input item moved during output stall");

endmodule

`default_nettype wire

[rtl/core/rou_alu.sv]
// ----------------------------------------------------------------------------
// rou_alu
// combinational rectangle datapath: one result per call, subtract pieces
// selected one at a time by the mask of pieces already sent
// ----------------------------------------------------------------------------
`default_nettype none

module rou_alu #(
    parameter int COORD_WIDTH = rou_pkg::COORD_WIDTH_DEFAULT
) (
    input  wire rou_pkg::cmd_t                 cmd,
    input  wire logic signed [COORD_WIDTH-1:0] a_l,
    input  wire logic signed [COORD_WIDTH-1:0] a_t,
    input  wire logic signed [COORD_WIDTH-1:0] a_r,
    input  wire logic signed [COORD_WIDTH-1:0] a_b,
    input  wire logic signed [COORD_WIDTH-1:0] b_l,
    input  wire logic signed [COORD_WIDTH-1:0] b_t,
    input  wire logic signed [COORD_WIDTH-1:0] b_r,
    input  wire logic signed [COORD_WIDTH-1:0] b_b,
    input  wire logic [rou_pkg::N_PIECES-1:0]  done,
    output logic signed [COORD_WIDTH-1:0]      r_l,
    output logic signed [COORD_WIDTH-1:0]      r_t,
    output logic signed [COORD_WIDTH-1:0]      r_r,
    output logic signed [COORD_WIDTH-1:0]      r_b,
    output rou_pkg::alu_status_t               status
);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct {
        coord_t l;
        coord_t t;
        coord_t r;
        coord_t b;
    } box_t;

    function automatic coord_t smax(input coord_t x, input coord_t y);
        return (x > y) ? x : y;
    endfunction

    function automatic coord_t smin(input coord_t x, input coord_t y);
        return (x < y) ? x : y;
    endfunction

    function automatic box_t norm(input box_t x);
        box_t y;
        y = x;
        if (x.l > x.r)
        begin
            y.l = x.r;
            y.r = x.l;
        end
        if (x.t > x.b)
        begin
            y.t = x.b;
            y.b = x.t;
        end
        return y;
    endfunction

    function automatic logic zero_area(input box_t x);
        return (x.l == x.r) || (x.t == x.b);
    endfunction

    box_t                      a;
    box_t                      b;
    box_t                      p;
    box_t                      q;
    box_t                      isect;
    box_t                      zbox;
    box_t                      res;
    box_t                      pc [rou_pkg::N_PIECES];
    logic                      overlap;
    logic                      h_same;
    logic                      v_same;
    logic                      v_touch;
    logic                      h_touch;
    coord_t                    s_top;
    coord_t                    s_bot;
    logic [rou_pkg::N_PIECES-1:0] mask;
    logic [rou_pkg::N_PIECES-1:0] rem;
    logic [rou_pkg::N_PIECES-1:0] low_bit;

    // operands and shared intermediates
    always_comb
    begin
        a = '{l: a_l, t: a_t, r: a_r, b: a_b};
        b = '{l: b_l, t: b_t, r: b_r, b: b_b};
        zbox = '{l: '0, t: '0, r: '0, b: '0};
        p = norm(a);
        q = norm(b);
        isect.l = smax(a.l, b.l);
        isect.t = smax(a.t, b.t);
        isect.r = smin(a.r, b.r);
        isect.b = smin(a.b, b.b);
        overlap = (isect.l < isect.r) && (isect.t < isect.b);
        h_same  = (p.l == q.l) && (p.r == q.r);
        v_same  = (p.t == q.t) && (p.b == q.b);
        v_touch = ((p.t <= q.t) && (q.t <= p.b)) || ((p.t >= q.t) && (q.b >= p.t));
        h_touch = ((p.l <= q.l) && (q.l <= p.r)) || ((p.l >= q.l) && (q.r >= p.l));
    end

    // subtract pieces in the order top, bottom, left, right
    always_comb
    begin
        s_top = (b.t > a.t) ? b.t : a.t;
        s_bot = (b.b < a.b) ? b.b : a.b;
        pc[0] = '{l: a.l, t: a.t, r: a.r, b: b.t};
        pc[1] = '{l: a.l, t: b.b, r: a.r, b: a.b};
        pc[2] = '{l: a.l, t: s_top, r: b.l, b: s_bot};
        pc[3] = '{l: b.r, t: s_top, r: a.r, b: s_bot};
        mask  = {b.r < a.r, b.l > a.l, b.b < a.b, b.t > a.t};
        if (!overlap)
        begin
            // disjoint: a itself is the only piece
            pc[0] = a;
            mask  = rou_pkg::N_PIECES'(1);
        end
        rem     = mask & ~done;
        low_bit = rem & (~rem + rou_pkg::N_PIECES'(1));
    end

    // command select
    always_comb
    begin
        res         = zbox;
        status.flag = 1'b0;
        status.last = 1'b1;
        status.pick = rou_pkg::N_PIECES'(1);
        case (cmd)
            rou_pkg::CMD_INTERSECT:
            begin
                res         = isect;
                status.flag = overlap;
            end
            rou_pkg::CMD_UNION:
            begin
                if (h_same)
                begin
                    if (v_touch)
                    begin
                        res         = '{l: p.l, t: smin(p.t, q.t), r: p.r, b: smax(p.b, q.b)};
                        status.flag = 1'b1;
                    end
                end
                else if (v_same && h_touch)
                begin
                    res         = '{l: smin(p.l, q.l), t: p.t, r: smax(p.r, q.r), b: p.b};
                    status.flag = 1'b1;
                end
            end
            rou_pkg::CMD_BOUND:
            begin
                if (zero_area(p))
                    res = q;
                else if (zero_area(q))
                    res = p;
                else
                    res = '{l: smin(p.l, q.l), t: smin(p.t, q.t),
                            r: smax(p.r, q.r), b: smax(p.b, q.b)};
                status.flag = !zero_area(res);
            end
            rou_pkg::CMD_SUBTRACT:
            begin
                if (mask != '0)
                begin
                    for (int k = 0; k < rou_pkg::N_PIECES; k++)
                    begin
                        if (low_bit[k])
                            res = pc[k];
                    end
                    status.flag = 1'b1;
                    status.last = (rem & ~low_bit) == '0;
                    status.pick = low_bit;
                end
            end
            rou_pkg::CMD_COVERED_BY:
                status.flag = !((a.l < b.l) || (a.t < b.t) || (a.r > b.r) || (a.b > b.b));
            rou_pkg::CMD_EQUAL:
                status.flag = (a.l == b.l) && (a.t == b.t) && (a.r == b.r) && (a.b == b.b);
            rou_pkg::CMD_IS_EMPTY:
                status.flag = zero_area(a);
            rou_pkg::CMD_NORMALIZE:
            begin
                res         = p;
                status.flag = !zero_area(p);
            end
            default:
            begin
                res = zbox;
            end
        endcase
        r_l = res.l;
        r_t = res.t;
        r_r = res.r;
        r_b = res.b;
    end

endmodule

`default_nettype wire

[test/rectangle_operation_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_operation_unit_tb
// self-checking bench for the clip-rectangle alu
// ----------------------------------------------------------------------------
// A queue of command items, directed corner cases first and then random
// rectangle pairs, feeds a clocked driver. Each accepted item is run through
// a local model of the rectangle operations, and its result items are queued.
// A clocked monitor pops them in order and compares every output field.
// Both sides idle at random, the receiver once holds off long enough to back
// up the input, and the sender twice waits for the unit to drain.
// ----------------------------------------------------------------------------

module rectangle_operation_unit_tb;

    typedef logic signed [rou_pkg::FIELD_W-1:0] coord_t;

    typedef struct packed {
        coord_t l;
        coord_t t;
        coord_t r;
        coord_t b;
    } rect_t;

    typedef struct packed {
        rou_pkg::cmd_t cmd;
        rect_t         a;
        rect_t         b;
        logic          wait_drain;
    } rect_item_t;

    typedef struct packed {
        rect_t box;
        logic  flag;
        logic  last;
    } rect_result_t;

    localparam int N_RANDOM      = 360;
    localparam int STALL_AT      = 60;
    localparam int STALL_CYCLES  = 40;
    localparam int CALM_FROM     = 150;
    localparam int CALM_TO       = 230;
    localparam int IDLE_PCT      = 18;
    localparam int WATCHDOG_MAX  = 1000;
    localparam int TAIL_CYCLES   = 8;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [2:0]           command = rou_pkg::CMD_INTERSECT;
    logic signed [rou_pkg::FIELD_W-1:0] a_left = '0;
    logic signed [rou_pkg::FIELD_W-1:0] a_top = '0;
    logic signed [rou_pkg::FIELD_W-1:0] a_right = '0;
    logic signed [rou_pkg::FIELD_W-1:0] a_bottom = '0;
    logic signed [rou_pkg::FIELD_W-1:0] b_left = '0;
    logic signed [rou_pkg::FIELD_W-1:0] b_top = '0;
    logic signed [rou_pkg::FIELD_W-1:0] b_right = '0;
    logic signed [rou_pkg::FIELD_W-1:0] b_bottom = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [rou_pkg::FIELD_W-1:0] res_left;
    logic signed [rou_pkg::FIELD_W-1:0] res_top;
    logic signed [rou_pkg::FIELD_W-1:0] res_right;
    logic signed [rou_pkg::FIELD_W-1:0] res_bottom;
    logic                 flag;
    logic                 last;

    rect_item_t   items_to_send[$];
    rect_result_t results_due[$];
    rect_item_t   cur_item;
    int           items_sent = 0;
    int           mismatches = 0;
    int           stall_left = 0;
    bit           stall_done = 1'b0;
    int           quiet_cycles = 0;
    logic         offer;

    rectangle_operation_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .a_left     (a_left),
        .a_top      (a_top),
        .a_right    (a_right),
        .a_bottom   (a_bottom),
        .b_left     (b_left),
        .b_top      (b_top),
        .b_right    (b_right),
        .b_bottom   (b_bottom),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .res_left   (res_left),
        .res_top    (res_top),
        .res_right  (res_right),
        .res_bottom (res_bottom),
        .flag       (flag),
        .last       (last)
    );

    // clock
    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // rectangle helpers
    // ------------------------------------------------------------------------
    function automatic coord_t cmax(coord_t x, coord_t y);
        return (x > y) ? x : y;
    endfunction

    function automatic coord_t cmin(coord_t x, coord_t y);
        return (x < y) ? x : y;
    endfunction

    function automatic rect_t box(int l, int t, int r, int b);
        return '{coord_t'(l), coord_t'(t), coord_t'(r), coord_t'(b)};
    endfunction

    // swap edges so that left <= right and top <= bottom
    function automatic rect_t normalise(rect_t x);
        coord_t l, t, r, b;
        rect_t  y;
        l = x.l;
        t = x.t;
        r = x.r;
        b = x.b;
        y = x;
        if (l > r)
        begin
            y.l = r;
            y.r = l;
        end
        if (t > b)
        begin
            y.t = b;
            y.b = t;
        end
        return y;
    endfunction

    function automatic bit has_no_area(rect_t x);
        return (x.l == x.r) || (x.t == x.b);
    endfunction

    function automatic void due(rect_t bx, bit fl, bit ls);
        rect_result_t res;
        res.box  = bx;
        res.flag = fl;
        res.last = ls;
        results_due.push_back(res);
    endfunction

    // ------------------------------------------------------------------------
    // expected result items of one command item
    // ------------------------------------------------------------------------
    function automatic void predict_rect_op(rect_item_t it);
        coord_t al, at, ar, ab, bl, bt, br, bb;
        coord_t pl, pt, pr, pb, ql, qt, qr, qb;
        coord_t st, sb;
        rect_t  p, q, r;
        rect_t  cut[rou_pkg::N_PIECES];
        int     n;
        bit     ok;
        al = it.a.l; at = it.a.t; ar = it.a.r; ab = it.a.b;
        bl = it.b.l; bt = it.b.t; br = it.b.r; bb = it.b.b;
        p = normalise(it.a);
        q = normalise(it.b);
        pl = p.l; pt = p.t; pr = p.r; pb = p.b;
        ql = q.l; qt = q.t; qr = q.r; qb = q.b;
        n = 0;
        ok = 1'b0;
        r = '0;
        case (it.cmd)
            rou_pkg::CMD_INTERSECT:
            begin
                r = '{cmax(al, bl), cmax(at, bt), cmin(ar, br), cmin(ab, bb)};
                due(r, (cmax(al, bl) < cmin(ar, br)) && (cmax(at, bt) < cmin(ab, bb)), 1'b1);
            end
            rou_pkg::CMD_UNION:
            begin
                // merge only along a shared pair of edges with contact
                if (pl == ql && pr == qr)
                begin
                    if ((pt <= qt && qt <= pb) || (pt >= qt && qb >= pt))
                    begin
                        ok = 1'b1;
                        r  = '{pl, cmin(pt, qt), pr, cmax(pb, qb)};
                    end
                end
                else if (pt == qt && pb == qb)
                begin
                    if ((pl <= ql && ql <= pr) || (pl >= ql && qr >= pl))
                    begin
                        ok = 1'b1;
                        r  = '{cmin(pl, ql), pt, cmax(pr, qr), pb};
                    end
                end
                due(ok ? r : rect_t'('0), ok, 1'b1);
            end
            rou_pkg::CMD_BOUND:
            begin
                // an empty side drops out of the bounding box
                if (has_no_area(p))
                    r = q;
                else if (has_no_area(q))
                    r = p;
                else
                    r = '{cmin(pl, ql), cmin(pt, qt), cmax(pr, qr), cmax(pb, qb)};
                due(r, !has_no_area(r), 1'b1);
            end
            rou_pkg::CMD_SUBTRACT:
            begin
                if (!((cmax(al, bl) < cmin(ar, br)) && (cmax(at, bt) < cmin(ab, bb))))
                    due(it.a, 1'b1, 1'b1);
                else
                begin
                    // cut top, bottom, left, right
                    st = at;
                    sb = ab;
                    if (bt > st)
                    begin
                        cut[n] = '{al, st, ar, bt};
                        n++;
                        st = bt;
                    end
                    if (bb < sb)
                    begin
                        cut[n] = '{al, bb, ar, sb};
                        n++;
                        sb = bb;
                    end
                    if (bl > al)
                    begin
                        cut[n] = '{al, st, bl, sb};
                        n++;
                    end
                    if (br < ar)
                    begin
                        cut[n] = '{br, st, ar, sb};
                        n++;
                    end
                    if (n == 0)
                        due('0, 1'b0, 1'b1);
                    for (int k = 0; k < n; k++)
                        due(cut[k], 1'b1, k == n - 1);
                end
            end
            rou_pkg::CMD_COVERED_BY:
                due('0, !(al < bl || at < bt || ar > br || ab > bb), 1'b1);
            rou_pkg::CMD_EQUAL:
                due('0, it.a == it.b, 1'b1);
            rou_pkg::CMD_IS_EMPTY:
                due('0, has_no_area(it.a), 1'b1);
            default:
                due(p, !has_no_area(p), 1'b1);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus construction
    // ------------------------------------------------------------------------
    function automatic void queue_item(rou_pkg::cmd_t c, rect_t a, rect_t b, bit drain);
        rect_item_t it;
        it.cmd        = c;
        it.a          = a;
        it.b          = b;
        it.wait_drain = drain;
        items_to_send.push_back(it);
    endfunction

    function automatic coord_t extreme_coord();
        case ($urandom_range(0, 3))
            0:       return coord_t'(-32768);
            1:       return coord_t'(32767);
            2:       return coord_t'(-1);
            default: return coord_t'(0);
        endcase
    endfunction

    // mostly well-formed small rectangles near a centre point
    function automatic rect_t rand_rect(int centre);
        int l, t, w, h;
        l = centre + int'($urandom_range(0, 40)) - 20;
        t = centre + int'($urandom_range(0, 40)) - 20;
        w = $urandom_range(0, 24);
        h = $urandom_range(0, 24);
        case ($urandom_range(0, 9))
            0:       return '{coord_t'($urandom), coord_t'($urandom),
                              coord_t'($urandom), coord_t'($urandom)};
            1:       return box(l + w, t, l, t + h);
            2:       return box(l, t + h, l + w, t);
            3:       return '{extreme_coord(), extreme_coord(),
                              extreme_coord(), extreme_coord()};
            default: return box(l, t, l + w, t + h);
        endcase
    endfunction

    function automatic void queue_random_item(bit drain);
        int            centre;
        rou_pkg::cmd_t c;
        rect_t         a, b;
        case ($urandom_range(0, 9))
            8:       centre = 32760;
            9:       centre = -32760;
            default: centre = int'($urandom_range(0, 200)) - 100;
        endcase
        c = rou_pkg::cmd_t'($urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0)
            c = rou_pkg::CMD_SUBTRACT;
        a = rand_rect(centre);
        b = rand_rect(centre);
        // related pairs so that merges, covers and equality occur
        case ($urandom_range(0, 7))
            0:
                b = a;
            1:
            begin
                b.l = a.l;
                b.r = a.r;
            end
            2:
            begin
                b.t = a.t;
                b.b = a.b;
            end
            3:
            begin
                b   = a;
                b.t = a.b;
                b.b = coord_t'(a.b + coord_t'($urandom_range(0, 20)));
            end
            4:
            begin
                b.l = coord_t'(a.l + int'($urandom_range(0, 4)) - 2);
                b.t = coord_t'(a.t + int'($urandom_range(0, 4)) - 2);
                b.r = coord_t'(a.r + int'($urandom_range(0, 4)) - 2);
                b.b = coord_t'(a.b + int'($urandom_range(0, 4)) - 2);
            end
            default:
                ;
        endcase
        queue_item(c, a, b, drain);
    endfunction

    // ------------------------------------------------------------------------
    // idling
    // ------------------------------------------------------------------------
    function automatic bit take_break();
        if (items_sent >= CALM_FROM && items_sent < CALM_TO)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // ------------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            offer = in_valid;
            if (in_valid && in_ready)
            begin
                predict_rect_op(cur_item);
                items_sent++;
                offer = 1'b0;
            end
            // a draining item waits for every outstanding result
            if (!offer && items_to_send.size() != 0 && !take_break()
                && !(items_to_send[0].wait_drain && results_due.size() != 0))
            begin
                cur_item = items_to_send.pop_front();
                offer    = 1'b1;
                command  <= cur_item.cmd;
                a_left   <= cur_item.a.l;
                a_top    <= cur_item.a.t;
                a_right  <= cur_item.a.r;
                a_bottom <= cur_item.a.b;
                b_left   <= cur_item.b.l;
                b_top    <= cur_item.b.t;
                b_right  <= cur_item.b.r;
                b_bottom <= cur_item.b.b;
            end
            in_valid <= offer;
        end
    end

    // ------------------------------------------------------------------------
    // monitor and checker
    // ------------------------------------------------------------------------
    task automatic report(string what, logic [rou_pkg::FIELD_W-1:0] want,
                          logic [rou_pkg::FIELD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %0d got %0d", $time, what,
                     $signed(want), $signed(got));
            mismatches++;
        end
    endtask

    task automatic check_result();
        rect_result_t want;
        if (results_due.size() == 0)
        begin
            $display("%0t ns: unexpected item, expected none got %0d %0d %0d %0d %s",
                     $time, res_left, res_top, res_right, res_bottom,
                     $sformatf("flag %0b last %0b", flag, last));
            mismatches++;
        end
        else
        begin
            want = results_due.pop_front();
            report("res_left", want.box.l, res_left);
            report("res_top", want.box.t, res_top);
            report("res_right", want.box.r, res_right);
            report("res_bottom", want.box.b, res_bottom);
            report("flag", 16'(want.flag), 16'(flag));
            report("last", 16'(want.last), 16'(last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            // one long hold-off to back the unit up
            if (!stall_done && items_sent >= STALL_AT)
            begin
                stall_left = STALL_CYCLES;
                stall_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= !take_break();
        end
    end

    // ------------------------------------------------------------------------
    // watchdog on cycles with no handshake
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        // intersect: overlap, disjoint, full range
        queue_item(rou_pkg::CMD_INTERSECT, box(0, 0, 10, 10), box(5, 5, 20, 20), 1'b0);
        queue_item(rou_pkg::CMD_INTERSECT, box(0, 0, 10, 10), box(20, 20, 30, 30), 1'b0);
        queue_item(rou_pkg::CMD_INTERSECT, box(-32768, -32768, 32767, 32767),
                   box(-32768, -32768, 32767, 32767), 1'b0);
        // union: touching columns, gap, inverted rows overlap, no shared edges
        queue_item(rou_pkg::CMD_UNION, box(0, 0, 10, 10), box(0, 10, 10, 20), 1'b0);
        queue_item(rou_pkg::CMD_UNION, box(0, 0, 10, 10), box(0, 11, 10, 20), 1'b0);
        queue_item(rou_pkg::CMD_UNION, box(10, 0, 0, 5), box(5, 0, 20, 5), 1'b0);
        queue_item(rou_pkg::CMD_UNION, box(0, 0, 10, 10), box(1, 1, 5, 5), 1'b0);
        // bound: empty a, empty b, both real, inverted a
        queue_item(rou_pkg::CMD_BOUND, box(3, 3, 3, 9), box(0, 0, 4, 4), 1'b0);
        queue_item(rou_pkg::CMD_BOUND, box(0, 0, 4, 4), box(7, 7, 9, 7), 1'b0);
        queue_item(rou_pkg::CMD_BOUND, box(0, 0, 4, 4), box(10, -5, 12, 2), 1'b0);
        queue_item(rou_pkg::CMD_BOUND, box(4, 4, 0, 0), box(5, 5, 5, 5), 1'b0);
        // subtract: disjoint, fully covered, hole in the middle, corner, full range
        queue_item(rou_pkg::CMD_SUBTRACT, box(0, 0, 10, 10), box(20, 20, 30, 30), 1'b0);
        queue_item(rou_pkg::CMD_SUBTRACT, box(2, 2, 8, 8), box(0, 0, 10, 10), 1'b0);
        queue_item(rou_pkg::CMD_SUBTRACT, box(0, 0, 10, 10), box(3, 3, 6, 6), 1'b0);
        queue_item(rou_pkg::CMD_SUBTRACT, box(0, 0, 10, 10), box(-5, -5, 4, 4), 1'b0);
        queue_item(rou_pkg::CMD_SUBTRACT, box(-32768, -32768, 32767, 32767),
                   box(-1, -1, 0, 0), 1'b0);
        // predicates
        queue_item(rou_pkg::CMD_COVERED_BY, box(2, 2, 8, 8), box(0, 0, 10, 10), 1'b0);
        queue_item(rou_pkg::CMD_COVERED_BY, box(0, 0, 10, 10), box(2, 2, 8, 8), 1'b0);
        queue_item(rou_pkg::CMD_EQUAL, box(1, 2, 3, 4), box(1, 2, 3, 4), 1'b0);
        queue_item(rou_pkg::CMD_EQUAL, box(1, 2, 3, 4), box(1, 2, 3, 5), 1'b0);
        queue_item(rou_pkg::CMD_IS_EMPTY, box(5, 0, 5, 10), box(0, 0, 0, 0), 1'b0);
        queue_item(rou_pkg::CMD_IS_EMPTY, box(0, 0, 1, 1), box(0, 0, 0, 0), 1'b0);
        queue_item(rou_pkg::CMD_IS_EMPTY, box(10, 10, 0, 0), box(0, 0, 0, 0), 1'b0);
        // normalize: inverted, and full range inverted after a drain
        queue_item(rou_pkg::CMD_NORMALIZE, box(10, 20, -10, -20), box(0, 0, 0, 0), 1'b0);
        queue_item(rou_pkg::CMD_NORMALIZE, box(32767, 32767, -32768, -32768),
                   box(-1, -1, -1, -1), 1'b1);

        // random pairs, with one more drain pause partway through
        for (int i = 0; i < N_RANDOM; i++)
            queue_random_item(i == 120);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (items_to_send.size() != 0 || in_valid)
            @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
